/* rtl/fds_pkg.sv */
package fds_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int TIME_BITS  = 24;

    localparam int IDX_W   = $clog2(MAX_FRAMES);
    localparam int ACC_W   = TIME_BITS + 9;
    localparam int SPEED_W = 16;
    localparam int FRAC_W  = 8;
    localparam int MUL_W   = TIME_BITS + SPEED_W;
    localparam int PROD_W  = MUL_W - FRAC_W;
    localparam int SUM_W   = TIME_BITS + IDX_W;
    localparam int DCNT_W  = $clog2(ACC_W);
    localparam int COUNT_W = 5;
    localparam int SLOT_W  = 4;
    localparam int FRAME_W = 4;
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PLAY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
    localparam logic [1:0] REG_LOOPING     = 2'd1;
    localparam logic [1:0] REG_SPEED       = 2'd2;

    localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 5'd1;
    localparam logic               LOOPING_RST     = 1'b1;
    localparam logic [SPEED_W-1:0] SPEED_RST       = 16'd256;

    typedef struct packed {
        logic [COUNT_W-1:0] frame_count;
        logic               looping;
        logic [SPEED_W-1:0] speed_factor;
    } cfg_t;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic add_acc;
        logic step;
        logic sum_clear;
        logic sum_acc;
        logic div_load_dur;
        logic div_load_sum;
        logic div_step;
        logic div_finish;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic tick_active;
        logic step_done;
        logic step_hold;
        logic step_wrap;
        logic sweep_last;
        logic div_last;
        logic out_busy;
    } stat_t;

endpackage

/* rtl/fds_datapath.sv */
module fds_datapath
    import fds_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  cfg_t                 cfg,
    input  logic [MODE_W-1:0]    mode,
    input  logic [TIME_BITS-1:0] elapsed_us,
    input  logic [SLOT_W-1:0]    frame_slot,
    input  logic [TIME_BITS-1:0] duration_us,
    input  logic                 restart_play,
    input  logic                 result_ready,
    output logic                 result_valid,
    output logic [FRAME_W-1:0]   frame_index,
    output logic                 running
);

    // Latched transaction
    logic [MODE_W-1:0]    mode_reg;
    logic [TIME_BITS-1:0] elapsed_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [TIME_BITS-1:0] dur_in_reg;
    logic                 restart_reg;

    // Sequence state
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic                 valid_reg, valid_next;

    logic [PROD_W-1:0]    prod_reg;
    logic [MUL_W-1:0]     prod_full;

    // Duration store
    logic [TIME_BITS-1:0] mem [MAX_FRAMES];
    logic [TIME_BITS-1:0] rdata_reg;
    logic [IDX_W-1:0]     rd_addr;

    // Sweep over the frames in use for the loop length
    logic [IDX_W-1:0]     swp_reg;
    logic [SUM_W-1:0]     sum_reg, sum_next;

    // Remainder unit
    logic [SUM_W-1:0]     div_d_reg;
    logic [ACC_W-1:0]     div_a_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [DCNT_W-1:0]    div_cnt_reg;
    logic [SUM_W:0]       trial;
    logic [SUM_W:0]       rem_new;

    logic                 out_valid_reg;
    logic [FRAME_W-1:0]   frame_index_reg;
    logic                 running_reg;

    logic [IDX_W-1:0]     last_idx;
    logic [IDX_W-1:0]     cur_clamp;
    logic [IDX_W-1:0]     slot_clamp;
    logic [TIME_BITS-1:0] dur_d;
    logic                 acc_ge;
    logic                 at_last;
    logic                 hold_case;

    always_comb
    begin
        if (cfg.frame_count == '0)
        begin
            last_idx = '0;
        end
        else if (32'(cfg.frame_count) > MAX_FRAMES)
        begin
            last_idx = IDX_W'(MAX_FRAMES - 1);
        end
        else
        begin
            last_idx = IDX_W'(cfg.frame_count - COUNT_W'(1));
        end
    end

    assign cur_clamp  = (cur_reg > last_idx) ? last_idx : cur_reg;
    assign slot_clamp = (32'(slot_reg) > 32'(last_idx)) ? last_idx : IDX_W'(slot_reg);

    // A zero entry counts as one so that stepping always ends.
    assign dur_d     = (rdata_reg == '0) ? TIME_BITS'(1) : rdata_reg;
    assign acc_ge    = acc_reg >= ACC_W'(dur_d);
    assign at_last   = (cur_reg == last_idx);
    assign hold_case = at_last && !cfg.looping;

    assign prod_full = MUL_W'(elapsed_reg) * MUL_W'(cfg.speed_factor);
    assign sum_next  = sum_reg + SUM_W'(dur_d);

    assign trial   = {rem_reg, div_a_reg[ACC_W-1]};
    assign rem_new = (trial >= {1'b0, div_d_reg}) ? (trial - {1'b0, div_d_reg}) : trial;

    always_comb
    begin
        cur_next   = cur_reg;
        acc_next   = acc_reg;
        valid_next = valid_reg;
        if (cmd.exec)
        begin
            if (mode_reg == MODE_TICK)
            begin
                if (valid_reg)
                begin
                    cur_next = cur_clamp;
                end
            end
            else if (mode_reg == MODE_PLAY)
            begin
                if (!valid_reg || restart_reg)
                begin
                    cur_next = slot_clamp;
                    acc_next = '0;
                end
                valid_next = 1'b1;
            end
        end
        if (cmd.add_acc)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.step && acc_ge && !hold_case)
        begin
            acc_next = acc_reg - ACC_W'(dur_d);
            cur_next = at_last ? '0 : cur_reg + IDX_W'(1);
        end
        if (cmd.div_finish)
        begin
            acc_next = ACC_W'(rem_new);
        end
    end

    // The read address runs ahead of its use.
    assign rd_addr = cmd.sum_acc ? (swp_reg + IDX_W'(1)) : cur_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cur_reg       <= '0;
            valid_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            cur_reg   <= cur_next;
            valid_reg <= valid_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg    <= mode;
            elapsed_reg <= elapsed_us;
            slot_reg    <= frame_slot;
            dur_in_reg  <= duration_us;
            restart_reg <= restart_play;
        end
        if (cmd.exec)
        begin
            prod_reg <= prod_full[MUL_W-1:FRAC_W];
        end
        if (cmd.sum_clear)
        begin
            swp_reg <= '0;
            sum_reg <= '0;
        end
        else if (cmd.sum_acc)
        begin
            swp_reg <= swp_reg + IDX_W'(1);
            sum_reg <= sum_next;
        end
        if (cmd.div_load_dur)
        begin
            div_d_reg   <= SUM_W'(dur_d);
            div_a_reg   <= acc_reg;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_load_sum)
        begin
            div_d_reg   <= sum_next;
            div_a_reg   <= acc_reg;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_new[SUM_W-1:0];
            div_a_reg   <= {div_a_reg[ACC_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
        end
        if (cmd.out_load)
        begin
            frame_index_reg <= FRAME_W'(cur_reg);
            running_reg     <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && (mode_reg == MODE_WRITE) && (32'(slot_reg) < MAX_FRAMES))
        begin
            mem[IDX_W'(slot_reg)] <= (dur_in_reg == '0) ? TIME_BITS'(1) : dur_in_reg;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign stat.tick_active = (mode_reg == MODE_TICK) && valid_reg;
    assign stat.step_done   = !acc_ge;
    assign stat.step_hold   = acc_ge && hold_case;
    assign stat.step_wrap   = acc_ge && at_last && cfg.looping;
    assign stat.sweep_last  = (swp_reg == last_idx);
    assign stat.div_last    = (div_cnt_reg == DCNT_W'(ACC_W - 1));
    assign stat.out_busy    = out_valid_reg && !result_ready;

    assign result_valid = out_valid_reg;
    assign frame_index  = frame_index_reg;
    assign running      = running_reg;

endmodule

/* rtl/fds_ctrl.sv */
module fds_ctrl
    import fds_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_ADD  = 7'b0000100,
        S_STEP = 7'b0001000,
        S_SUM  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   reduced_reg, reduced_next;
    logic   hold_div_reg, hold_div_next;

    always_comb
    begin
        state_next    = state_reg;
        reduced_next  = reduced_reg;
        hold_div_next = hold_div_reg;
        cmd           = '0;
        item_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item_ready    = 1'b1;
                cmd.load_item = item_valid;
                if (item_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.tick_active)
                begin
                    reduced_next = 1'b0;
                    state_next   = S_ADD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ADD:
            begin
                cmd.add_acc = 1'b1;
                state_next  = S_STEP;
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                priority if (stat.step_done)
                begin
                    state_next = S_DONE;
                end
                else if (stat.step_hold)
                begin
                    cmd.div_load_dur = 1'b1;
                    hold_div_next    = 1'b1;
                    state_next       = S_DIV;
                end
                else if (stat.step_wrap && !reduced_reg)
                begin
                    // First wrap: fold the remaining time modulo the loop length.
                    cmd.sum_clear = 1'b1;
                    state_next    = S_SUM;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_SUM:
            begin
                cmd.sum_acc = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.div_load_sum = 1'b1;
                    hold_div_next    = 1'b0;
                    state_next       = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    cmd.div_finish = 1'b1;
                    if (hold_div_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        reduced_next = 1'b1;
                        state_next   = S_STEP;
                    end
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            reduced_reg  <= 1'b0;
            hold_div_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            reduced_reg  <= reduced_next;
            hold_div_reg <= hold_div_next;
        end
    end

endmodule

/* rtl/frame_duration_sequencer_core.sv */
// Frame duration sequencer.
// Input channel (item_valid/item_ready) carries one transaction per item: a tick
// (mode 0) adds elapsed_us scaled by the 8.8 speed factor, a play (mode 1) starts
// the sequence at frame_slot if not yet running or on restart_play, a write
// (mode 2) loads one frame's duration. Every transaction yields exactly one
// result transaction (result_valid/result_ready) with the current frame index
// and the running flag. The block works on one transaction at a time. Play,
// write, mode three and a tick before the first play pass from accept through
// execute to done. A tick while running also adds its scaled time and steps
// frames, one frame per cycle while no fold runs, through the duration store's
// registered read port. When the sequence wraps for the first time in a tick,
// a sweep over the frames in use sums the loop length and a radix-2 remainder
// unit folds the time; holding the last frame uses the same remainder unit.
// The result sits in an output register; while it is not taken the next
// transaction is still accepted and worked on, and stalls only at its own result.
// Reset clears the current frame, the accumulator and the playing state and
// loads the registers with frame_count 1, looping 1 and speed 256; frame
// durations stay undefined until written. The user must ensure that registers
// are written over the APB port only while the block is idle (not enforced).
module frame_duration_sequencer_core
    import fds_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [MODE_W-1:0]    mode,
    input  logic [TIME_BITS-1:0] elapsed_us,
    input  logic [SLOT_W-1:0]    frame_slot,
    input  logic [TIME_BITS-1:0] duration_us,
    input  logic                 restart_play,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [FRAME_W-1:0]   frame_index,
    output logic                 running
);

    logic [COUNT_W-1:0] frame_count_reg;
    logic               looping_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic               apb_write;
    cfg_t               cfg;
    cmd_t               cmd;
    stat_t              stat;

    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FRAME_COUNT_RST;
            looping_reg     <= LOOPING_RST;
            speed_reg       <= SPEED_RST;
        end
        else if (apb_write)
        begin
            if (paddr[3:2] == REG_FRAME_COUNT)
            begin
                frame_count_reg <= pwdata[COUNT_W-1:0];
            end
            if (paddr[3:2] == REG_LOOPING)
            begin
                looping_reg <= pwdata[0];
            end
            if (paddr[3:2] == REG_SPEED)
            begin
                speed_reg <= pwdata[SPEED_W-1:0];
            end
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FRAME_COUNT: prdata = DATA_W'(frame_count_reg);
            REG_LOOPING:     prdata = DATA_W'(looping_reg);
            REG_SPEED:       prdata = DATA_W'(speed_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.frame_count  = frame_count_reg;
    assign cfg.looping      = looping_reg;
    assign cfg.speed_factor = speed_reg;

    fds_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    fds_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg          (cfg),
        .mode         (mode),
        .elapsed_us   (elapsed_us),
        .frame_slot   (frame_slot),
        .duration_us  (duration_us),
        .restart_play (restart_play),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .frame_index  (frame_index),
        .running      (running)
    );

endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fds_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 64;
    localparam int SHOWN_MISMATCH  = 10;
    localparam int RANDOM_ITEMS    = 690;
    localparam int RANDOM_PHASES   = 6;
    localparam int HOLD_OFF_CYCLES = 300;

    // Mode three has no function in the block; it only reports the state.
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               on;
    } frame_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 item_valid;
    logic                 item_ready;
    logic [MODE_W-1:0]    mode;
    logic [TIME_BITS-1:0] elapsed_us;
    logic [SLOT_W-1:0]    frame_slot;
    logic [TIME_BITS-1:0] duration_us;
    logic                 restart_play;
    logic                 result_valid;
    logic                 result_ready;
    logic [FRAME_W-1:0]   frame_index;
    logic                 running;

    // Sequencer state as the block should hold it.
    logic [TIME_BITS-1:0] duration_table [MAX_FRAMES];
    logic [ACC_W-1:0]     accum;
    logic [FRAME_W-1:0]   frame_now;
    logic                 playing;
    logic [COUNT_W-1:0]   cfg_count;
    logic                 cfg_loop;
    logic [SPEED_W-1:0]   cfg_speed;

    frame_report_t expected_frames [$];

    int  mismatch_count;
    int  results_seen;
    int  tick_items;
    int  play_items;
    int  write_items;
    int  reserved_items;
    int  wrap_folds;
    int  last_frame_holds;
    int  settings_applied;
    int  sink_hold_cycles;
    bit  src_idle_on;
    bit  sink_idle_on;

    frame_duration_sequencer_core u_top (.*);

    always #5 clk = ~clk;

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] stored_duration(input int idx);
        logic [63:0] d;
        d = 64'(duration_table[idx]);
        return (d == 0) ? 64'd1 : d;
    endfunction

    function automatic frame_report_t predict_frame(
        input logic [MODE_W-1:0]    m,
        input logic [TIME_BITS-1:0] el,
        input logic [SLOT_W-1:0]    sl,
        input logic [TIME_BITS-1:0] du,
        input logic                 rs
    );
        int            n;
        int            c;
        int            i;
        logic [63:0]   a;
        logic [63:0]   d;
        logic [63:0]   total;
        bit            folded;
        frame_report_t rep;

        n = int'(cfg_count);
        if (n == 0) n = 1;
        if (n > MAX_FRAMES) n = MAX_FRAMES;

        case (m)
            MODE_TICK:
            begin
                if (playing)
                begin
                    c = int'(frame_now);
                    if (c >= n) c = n - 1;
                    a = 64'(accum) + ((64'(el) * 64'(cfg_speed)) >> FRAC_W);
                    folded = 1'b0;
                    while (1'b1)
                    begin
                        d = stored_duration(c);
                        if (a < d) break;
                        if (c == n - 1 && !cfg_loop)
                        begin
                            a = a % d;
                            last_frame_holds++;
                            break;
                        end
                        a = a - d;
                        c++;
                        if (c >= n)
                        begin
                            c = 0;
                            // The first wrap folds the time by the full loop length.
                            if (!folded)
                            begin
                                total = 0;
                                for (i = 0; i < n; i++) total += stored_duration(i);
                                a = a % total;
                                folded = 1'b1;
                                wrap_folds++;
                            end
                        end
                    end
                    frame_now = FRAME_W'(c);
                    accum = ACC_W'(a);
                end
            end
            MODE_PLAY:
            begin
                if (!playing || rs)
                begin
                    frame_now = (int'(sl) >= n) ? FRAME_W'(n - 1) : FRAME_W'(sl);
                    accum = '0;
                end
                playing = 1'b1;
            end
            MODE_WRITE:
                duration_table[sl] = (du == 0) ? TIME_BITS'(1) : du;
            default: ;
        endcase

        rep.frame = frame_now;
        rep.on    = playing;
        return rep;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < SHOWN_MISMATCH) $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_item(
        input logic [MODE_W-1:0]    m,
        input logic [TIME_BITS-1:0] el,
        input logic [SLOT_W-1:0]    sl,
        input logic [TIME_BITS-1:0] du,
        input logic                 rs
    );
        int gap;
        @(negedge clk);
        gap = src_idle_on ? idle_length() : 0;
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode         = m;
        elapsed_us   = el;
        frame_slot   = sl;
        duration_us  = du;
        restart_play = rs;
        item_valid   = 1'b1;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        expected_frames = {expected_frames, predict_frame(m, el, sl, du, rs)};
        case (m)
            MODE_TICK:  tick_items++;
            MODE_PLAY:  play_items++;
            MODE_WRITE: write_items++;
            default:    reserved_items++;
        endcase
    endtask

    // Lets every outstanding result come back before registers are touched.
    task automatic wait_idle();
        @(negedge clk);
        item_valid = 1'b0;
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        case (index)
            REG_FRAME_COUNT: cfg_count = value[COUNT_W-1:0];
            REG_LOOPING:     cfg_loop  = value[0];
            REG_SPEED:       cfg_speed = value[SPEED_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input int count, input int loop_on, input int speed);
        wait_idle();
        write_register(REG_FRAME_COUNT, DATA_W'(count));
        write_register(REG_LOOPING, DATA_W'(loop_on));
        write_register(REG_SPEED, DATA_W'(speed));
        settings_applied++;
    endtask

    function automatic logic [TIME_BITS-1:0] random_elapsed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return TIME_BITS'($urandom_range(0, 2000));
        if (r < 95) return TIME_BITS'($urandom_range(0, 65535));
        return TIME_BITS'($urandom());
    endfunction

    function automatic logic [TIME_BITS-1:0] random_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 13) return '1;
        if (r < 23) return TIME_BITS'($urandom());
        return TIME_BITS'($urandom_range(1, 1000));
    endfunction

    task automatic send_random_item();
        int                r;
        logic [MODE_W-1:0] m;
        r = $urandom_range(0, 99);
        if (r < 62) m = MODE_TICK;
        else if (r < 77) m = MODE_PLAY;
        else if (r < 95) m = MODE_WRITE;
        else m = MODE_RESERVED;
        send_item(m, random_elapsed(), SLOT_W'($urandom_range(0, MAX_FRAMES - 1)),
                  random_duration(), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_ticks_before_play();
        send_item(MODE_TICK, '0, 4'd0, 24'd5, 1'b0);
        send_item(MODE_TICK, '1, 4'd15, '1, 1'b1);
        send_item(MODE_RESERVED, '1, 4'd7, '1, 1'b1);
    endtask

    task automatic test_duration_writes();
        send_item(MODE_WRITE, '0, 4'd0, '0, 1'b0);
        send_item(MODE_WRITE, '0, 4'd1, 24'd100, 1'b0);
        send_item(MODE_WRITE, '0, 4'd2, 24'd250, 1'b1);
        send_item(MODE_WRITE, '0, 4'd3, 24'd40, 1'b0);
        send_item(MODE_WRITE, '1, 4'd15, '1, 1'b0);
    endtask

    task automatic test_play_and_step();
        set_config(4, 1, 256);
        send_item(MODE_PLAY, '0, 4'd15, '0, 1'b0);
        send_item(MODE_TICK, 24'd39, 4'd0, '0, 1'b0);
        send_item(MODE_TICK, 24'd1, 4'd0, '0, 1'b0);
        send_item(MODE_TICK, 24'd1, 4'd0, '0, 1'b0);
        send_item(MODE_TICK, 24'd350, 4'd0, '0, 1'b0);
        send_item(MODE_PLAY, '0, 4'd1, '0, 1'b0);
        send_item(MODE_PLAY, '0, 4'd2, '0, 1'b1);
        send_item(MODE_TICK, '1, 4'd0, '0, 1'b0);
    endtask

    task automatic test_hold_and_count_edges();
        set_config(4, 0, 65535);
        send_item(MODE_PLAY, '0, 4'd3, '0, 1'b1);
        send_item(MODE_TICK, 24'd1, 4'd0, '0, 1'b0);
        send_item(MODE_TICK, '1, 4'd0, '0, 1'b0);
        // Count drops below the current frame, so the next tick clamps it.
        set_config(2, 0, 65535);
        send_item(MODE_TICK, '0, 4'd0, '0, 1'b0);
        set_config(2, 1, 0);
        send_item(MODE_TICK, '1, 4'd0, '0, 1'b0);
        set_config(0, 1, 256);
        send_item(MODE_TICK, 24'd3, 4'd0, '0, 1'b0);
        send_item(MODE_PLAY, '0, 4'd5, '0, 1'b1);
    endtask

    task automatic test_output_backpressure();
        int k;
        set_config(4, 1, 256);
        src_idle_on = 1'b0;
        sink_hold_cycles = HOLD_OFF_CYCLES;
        send_item(MODE_PLAY, '0, 4'd0, '0, 1'b1);
        for (k = 0; k < 24; k++)
        begin
            if (k % 6 == 5) send_item(MODE_WRITE, '0, SLOT_W'($urandom_range(0, 3)),
                                      random_duration(), 1'b0);
            else send_item(MODE_TICK, random_elapsed(), '0, '0, 1'b0);
        end
        src_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int phase;
        int k;
        // Every slot gets a duration before any count can reach it.
        for (k = 0; k < MAX_FRAMES; k++)
            send_item(MODE_WRITE, random_elapsed(), SLOT_W'(k), random_duration(), 1'b0);
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: set_config(16, 1, 256);
                1: set_config(31, 0, 65535);
                2: set_config(1, 1, 512);
                3: set_config(0, 0, 256);
                4: set_config($urandom_range(2, 15), 1, $urandom_range(0, 65535));
                default: set_config($urandom_range(1, 16), $urandom_range(0, 1),
                                    $urandom_range(64, 1024));
            endcase
            for (k = 0; k < RANDOM_ITEMS / RANDOM_PHASES; k++)
            begin
                // Every third stretch of 40 runs with no idling on either side.
                src_idle_on  = ((k / 40) % 3 != 2);
                sink_idle_on = src_idle_on;
                send_random_item();
            end
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial
    begin : result_sink
        int stall;
        stall = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_cycles > 0)
            begin
                result_ready = 1'b0;
                sink_hold_cycles--;
            end
            else if (stall > 0)
            begin
                result_ready = 1'b0;
                stall--;
            end
            else
            begin
                stall = sink_idle_on ? idle_length() : 0;
                result_ready = (stall == 0);
                if (stall > 0) stall--;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        frame_report_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (expected_frames.size() == 0)
                flag_mismatch($sformatf("unexpected result frame_index=%0d running=%0b",
                                        frame_index, running));
            else
            begin
                want = expected_frames.pop_front();
                if (frame_index !== want.frame)
                    flag_mismatch($sformatf("frame_index expected %0d, got %0d",
                                            want.frame, frame_index));
                if (running !== want.on)
                    flag_mismatch($sformatf("running expected %0b, got %0b",
                                            want.on, running));
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("frame_duration_sequencer_core regression: fail");
        $finish;
    end

    initial
    begin
        int k;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        item_valid   = 1'b0;
        mode         = MODE_TICK;
        elapsed_us   = '0;
        frame_slot   = '0;
        duration_us  = '0;
        restart_play = 1'b0;
        for (k = 0; k < MAX_FRAMES; k++) duration_table[k] = '0;
        accum            = '0;
        frame_now        = '0;
        playing          = 1'b0;
        cfg_count        = FRAME_COUNT_RST;
        cfg_loop         = LOOPING_RST;
        cfg_speed        = SPEED_RST;
        mismatch_count   = 0;
        results_seen     = 0;
        sink_hold_cycles = 0;
        src_idle_on      = 1'b1;
        sink_idle_on     = 1'b1;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_ticks_before_play();
        test_duration_writes();
        test_play_and_step();
        test_hold_and_count_edges();
        test_output_backpressure();
        test_random_traffic();

        @(negedge clk);
        item_valid = 1'b0;
        while (expected_frames.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d ticks, %0d plays, %0d duration writes and %0d reserved-mode items;",
                 tick_items, play_items, write_items, reserved_items);
        $display("%0d results checked, loop folds: %0d, last-frame holds: %0d,",
                 results_seen, wrap_folds, last_frame_holds);
        $display("register settings: %0d, mismatches: %0d.",
                 settings_applied, mismatch_count);
        if (mismatch_count == 0 && expected_frames.size() == 0)
            $display("frame_duration_sequencer_core regression: pass");
        else
            $display("frame_duration_sequencer_core regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/fds_pkg.sv
rtl/fds_datapath.sv
rtl/fds_ctrl.sv
rtl/frame_duration_sequencer_core.sv
tb/tb_top.sv
